@@ sv/dpr_pkg.sv @@
// Shared types, constants and helper functions of the disparity-to-point reprojector.
// Used by the pipelined divider and by the top level; depends on nothing else.
package dpr_pkg;

  // Significand of a half-precision code, with the implicit one.
  localparam int unsigned MAN_W       = 11;
  // Dividend of the long division: zero pad, 32-bit product, 21 fraction bits.
  localparam int unsigned PROD_W      = 32;
  localparam int unsigned FRAC_W      = 21;
  localparam int unsigned STG_BITS    = 8;
  localparam int unsigned DIV_STAGES  = 7;
  localparam int unsigned DIV_W       = STG_BITS * DIV_STAGES;
  localparam int unsigned PAD_W       = DIV_W - PROD_W - FRAC_W;
  // Magnitude after rounding; values of 2^24 and above mean overflow.
  localparam int unsigned MAG_W       = 25;
  localparam int unsigned COORD_W     = 24;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgFocalX    = 3'd0,
    CfgCenterX   = 3'd1,
    CfgCenterY   = 3'd2,
    CfgDepthNum  = 3'd3,
    CfgMinDepth  = 3'd4,
    CfgMaxDepth  = 3'd5,
    CfgDispFloor = 3'd6
  } cfg_idx_e;

  // Per-pixel sideband that travels alongside the divider lanes.
  typedef struct packed {
    logic       ok;
    logic       x_neg;
    logic       y_neg;
    logic [4:0] exp_sh;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } side_t;

  // Scale the quotient down by the exponent and round half away from zero.
  function automatic logic [MAG_W-1:0] round_mag(input logic [DIV_W-1:0] quot,
                                                 input logic [4:0] sh);
    logic [DIV_W-1:0] q_sh;
    logic [MAG_W:0]   sum;
    q_sh = quot >> sh;
    sum  = {1'b0, q_sh[MAG_W-1:0]} + {{MAG_W{1'b0}}, 1'b1};
    if (|q_sh[DIV_W-1:MAG_W]) begin
      round_mag = {1'b1, {(MAG_W-1){1'b0}}};
    end else begin
      round_mag = sum[MAG_W:1];
    end
  endfunction

  // Apply the sign and saturate to a signed 24-bit coordinate.
  function automatic logic signed [COORD_W-1:0] to_coord(input logic neg,
                                                         input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] diff;
    diff = {1'b1, {(MAG_W-1){1'b0}}} - mag;
    if (neg) begin
      if (mag >= {2'b01, {(MAG_W-2){1'b0}}}) begin
        to_coord = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        to_coord = diff[COORD_W-1:0];
      end
    end else begin
      if (mag > {2'b00, {(MAG_W-2){1'b1}}}) begin
        to_coord = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        to_coord = mag[COORD_W-1:0];
      end
    end
  endfunction

endpackage

@@ sv/dpr_div.sv @@
// Pipelined restoring long division, STG_BITS quotient bits per register stage.
// Depends on dpr_pkg for the widths and stage count.
module dpr_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [dpr_pkg::DIV_W-1:0]   dividend_i,
  input  logic [dpr_pkg::MAN_W-1:0]   divisor_i,
  output logic [dpr_pkg::DIV_W-1:0]   quot_o
);
  import dpr_pkg::*;

  logic [DIV_W-1:0] work_q [DIV_STAGES];
  logic [MAN_W-1:0] rem_q  [DIV_STAGES];
  logic [MAN_W-1:0] den_q  [DIV_STAGES];
  logic [DIV_W-1:0] work_d [DIV_STAGES];
  logic [MAN_W-1:0] rem_d  [DIV_STAGES];
  logic [MAN_W-1:0] den_d  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    // Each stage shifts in dividend bits and subtracts the divisor where it fits.
    always_comb begin
      logic [DIV_W-1:0] w;
      logic [MAN_W-1:0] r;
      logic [MAN_W-1:0] d;
      logic [MAN_W:0]   t;
      if (s == 0) begin
        w = dividend_i;
        r = '0;
        d = divisor_i;
      end else begin
        w = work_q[(s == 0) ? 0 : s-1];
        r = rem_q[(s == 0) ? 0 : s-1];
        d = den_q[(s == 0) ? 0 : s-1];
      end
      for (int b = 0; b < STG_BITS; b++) begin
        t = {r, w[DIV_W-1]};
        w = {w[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t    = t - {1'b0, d};
          w[0] = 1'b1;
        end
        r = t[MAN_W-1:0];
      end
      work_d[s] = w;
      rem_d[s]  = r;
      den_d[s]  = d;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        work_q[s] <= work_d[s];
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= den_d[s];
      end
    end
  end

  assign quot_o = work_q[DIV_STAGES-1];

endmodule

@@ sv/disparity_to_point_reprojector_top.sv @@
// Top level of the disparity-to-point reprojector: decode, products, divider lanes, output.
// Depends on dpr_pkg and dpr_div.
//
// Usage: one pixel word enters on the input channel (in_valid_i / in_stall_o) with its
// column, row, half-precision disparity and color bytes. Exactly one result word leaves
// on the output channel (out_valid_o / out_stall_i) for every pixel, in order: either a
// point with point_valid_o high, or an all-zero word with point_valid_o low when the
// disparity, the pixel position or the depth test rejects it.
// Configuration registers are written over cfg_valid_i / cfg_ready_o with cfg_index_i
// and cfg_data_i; cfg_ready_o is always high, unknown indexes are ignored. Write them
// only while no pixel is in flight.
// From acceptance to the result word a pixel passes decode, multiply, seven divider
// stages of eight quotient bits each, rounding, and the output register. Throughput
// is one pixel per cycle unless the receiver stalls; the division depth sets the latency.
// Reset clears every stage valid and loads the register defaults. When the receiver
// stalls a valid result, the whole pipeline holds and in_stall_o rises in the same
// cycle; nothing is dropped or repeated.
module disparity_to_point_reprojector_top #(
  parameter int unsigned MAX_COLUMNS = 2048,
  parameter int unsigned MAX_ROWS    = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [10:0] column_i,
  input  logic [10:0] row_i,
  input  logic [15:0] disparity_bits_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  // Point output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        point_valid_o,
  output logic signed [dpr_pkg::COORD_W-1:0] point_x_o,
  output logic signed [dpr_pkg::COORD_W-1:0] point_y_o,
  output logic signed [dpr_pkg::COORD_W-1:0] point_z_o,
  output logic [7:0]  point_red_o,
  output logic [7:0]  point_green_o,
  output logic [7:0]  point_blue_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import dpr_pkg::*;

  // Configuration registers.
  logic [15:0] focal_x_q, center_x_q, center_y_q, depth_num_q;
  logic [23:0] depth_lo_q, depth_hi_q;
  logic [14:0] disp_floor_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q    <= 16'd8000;
      center_x_q   <= 16'd6400;
      center_y_q   <= 16'd4800;
      depth_num_q  <= 16'd2560;
      depth_lo_q   <= 24'd0;
      depth_hi_q   <= 24'd25600;
      disp_floor_q <= 15'd1678;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgFocalX:    focal_x_q    <= cfg_data_i[15:0];
        CfgCenterX:   center_x_q   <= cfg_data_i[15:0];
        CfgCenterY:   center_y_q   <= cfg_data_i[15:0];
        CfgDepthNum:  depth_num_q  <= cfg_data_i[15:0];
        CfgMinDepth:  depth_lo_q   <= cfg_data_i;
        CfgMaxDepth:  depth_hi_q   <= cfg_data_i;
        CfgDispFloor: disp_floor_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one unless a finished word is held by the receiver.
  logic en;
  logic out_vld_q;
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 1: decode the half code, range checks, offsets from the principal point.
  logic [4:0]  hexp;
  logic [14:0] hmag;
  logic [16:0] cx_diff, cy_diff;
  side_t       s1_side_d;
  logic [MAN_W-1:0] s1_man_d;
  logic [15:0] s1_dx_d, s1_dy_d;

  always_comb begin
    hexp = disparity_bits_i[14:10];
    hmag = disparity_bits_i[14:0];
    s1_side_d.ok = !disparity_bits_i[15] && (hexp != 5'h1f) && (hmag != 15'd0) &&
                   (hmag >= disp_floor_q) &&
                   (32'(column_i) < MAX_COLUMNS) && (32'(row_i) < MAX_ROWS);
    s1_man_d = (hexp == 5'd0) ? {1'b0, disparity_bits_i[9:0]}
                              : {1'b1, disparity_bits_i[9:0]};
    s1_side_d.exp_sh = (hexp == 5'd0) ? 5'd0 : hexp - 5'd1;
    cx_diff = {2'b00, column_i, 4'b0000} - {1'b0, center_x_q};
    cy_diff = {2'b00, row_i, 4'b0000} - {1'b0, center_y_q};
    s1_side_d.x_neg = cx_diff[16];
    s1_side_d.y_neg = !cy_diff[16];
    s1_dx_d = cx_diff[16] ? 16'(-cx_diff) : cx_diff[15:0];
    s1_dy_d = cy_diff[16] ? 16'(-cy_diff) : cy_diff[15:0];
    s1_side_d.red   = red_i;
    s1_side_d.green = green_i;
    s1_side_d.blue  = blue_i;
  end

  logic        s1_vld_q;
  side_t       s1_side_q;
  logic [MAN_W-1:0] s1_man_q;
  logic [15:0] s1_dx_q, s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_side_q <= s1_side_d;
      s1_man_q  <= s1_man_d;
      s1_dx_q   <= s1_dx_d;
      s1_dy_q   <= s1_dy_d;
    end
  end

  // Stage 2: the three numerator products.
  logic        s2_vld_q;
  side_t       s2_side_q;
  logic [MAN_W-1:0]  s2_man_q;
  logic [PROD_W-1:0] s2_pz_q, s2_px_q, s2_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s1_side_q;
      s2_man_q  <= s1_man_q;
      s2_pz_q   <= depth_num_q * focal_x_q;
      s2_px_q   <= depth_num_q * s1_dx_q;
      s2_py_q   <= depth_num_q * s1_dy_q;
    end
  end

  // Divider lanes: quotient of product times 2^21 over the significand.
  logic [DIV_W-1:0] quot_z, quot_x, quot_y;

  dpr_div u_div_z (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({{PAD_W{1'b0}}, s2_pz_q, {FRAC_W{1'b0}}}),
    .divisor_i  (s2_man_q),
    .quot_o     (quot_z)
  );

  dpr_div u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({{PAD_W{1'b0}}, s2_px_q, {FRAC_W{1'b0}}}),
    .divisor_i  (s2_man_q),
    .quot_o     (quot_x)
  );

  dpr_div u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({{PAD_W{1'b0}}, s2_py_q, {FRAC_W{1'b0}}}),
    .divisor_i  (s2_man_q),
    .quot_o     (quot_y)
  );

  // Sideband and valid bits that keep step with the divider stages.
  logic  dv_vld_q  [DIV_STAGES];
  side_t dv_side_q [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[s] <= 1'b0;
      end else if (en) begin
        dv_vld_q[s] <= (s == 0) ? s2_vld_q : dv_vld_q[(s == 0) ? 0 : s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_side_q[s] <= (s == 0) ? s2_side_q : dv_side_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  // Stage A: exponent scaling and rounding of the three magnitudes.
  logic       a_vld_q;
  side_t      a_side_q;
  logic [MAG_W-1:0] a_zmag_q, a_xmag_q, a_ymag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= dv_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q <= dv_side_q[DIV_STAGES-1];
      a_zmag_q <= round_mag(quot_z, dv_side_q[DIV_STAGES-1].exp_sh);
      a_xmag_q <= round_mag(quot_x, dv_side_q[DIV_STAGES-1].exp_sh);
      a_ymag_q <= round_mag(quot_y, dv_side_q[DIV_STAGES-1].exp_sh);
    end
  end

  // Stage B: depth window, sign and saturation into the output register.
  logic keep;
  assign keep = a_side_q.ok && (a_zmag_q >= {1'b0, depth_lo_q}) &&
                (a_zmag_q <= {1'b0, depth_hi_q});

  logic                      pv_q;
  logic signed [COORD_W-1:0] px_q, py_q, pz_q;
  logic [7:0]                pr_q, pg_q, pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pv_q <= keep;
      px_q <= keep ? to_coord(a_side_q.x_neg, a_xmag_q) : '0;
      py_q <= keep ? to_coord(a_side_q.y_neg, a_ymag_q) : '0;
      pz_q <= keep ? to_coord(1'b1, a_zmag_q) : '0;
      pr_q <= keep ? a_side_q.red : 8'd0;
      pg_q <= keep ? a_side_q.green : 8'd0;
      pb_q <= keep ? a_side_q.blue : 8'd0;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign point_valid_o = pv_q;
  assign point_x_o     = px_q;
  assign point_y_o     = py_q;
  assign point_z_o     = pz_q;
  assign point_red_o   = pr_q;
  assign point_green_o = pg_q;
  assign point_blue_o  = pb_q;

endmodule
